@@ src/bmh_pkg.sv @@
// bmh_pkg: shared types and constants for the binary max-heap block.
// Depends on nothing; imported by bmh_ctrl and binary_max_heap.
`default_nettype none

package bmh_pkg;

	// fixed widths of the channel fields
	localparam int KEY_W = 32;
	localparam int CNT_W = 11;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_LOAD,
		ST_DOWN,
		ST_FIN
	} state_t;

	// end-of-operation notice from the sequencer to the result register
	typedef struct packed {
		logic    done;
		status_t status;
	} fin_t;

endpackage

`default_nettype wire

@@ src/bmh_store.sv @@
// bmh_store: heap key memory, one write port and two registered read ports.
// Depends on nothing; used by binary_max_heap.
`default_nettype none

module bmh_store #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32,
	localparam int AW = $clog2(CAPACITY)
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [AW-1:0]       waddr,
	input  wire logic [KEY_BITS-1:0] wdata,
	input  wire logic [AW-1:0]       raddr_a,
	input  wire logic [AW-1:0]       raddr_b,
	output logic      [KEY_BITS-1:0] rdata_a,
	output logic      [KEY_BITS-1:0] rdata_b
);

	logic [KEY_BITS-1:0] mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

@@ src/bmh_ctrl.sv @@
// bmh_ctrl: sequencer for insert (sift up) and remove-max (sift down).
// Depends on bmh_pkg; drives the ports of bmh_store.
`default_nettype none

module bmh_ctrl import bmh_pkg::*; #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire logic                command,
	input  wire logic [KEY_W-1:0]    key,
	input  wire logic                res_free,
	output fin_t                     fin,
	output logic      [CW-1:0]       cnt,
	output logic      [KEY_BITS-1:0] root,
	output logic                     we,
	output logic      [AW-1:0]       waddr,
	output logic      [KEY_BITS-1:0] wdata,
	output logic      [AW-1:0]       raddr_a,
	output logic      [AW-1:0]       raddr_b,
	input  wire logic [KEY_BITS-1:0] rdata_a,
	input  wire logic [KEY_BITS-1:0] rdata_b
);

	localparam int CIW = AW + 2;

	state_t              state_q, state_d;
	status_t             status_q, status_d;
	logic [AW-1:0]       pos_q, pos_d;
	logic [KEY_BITS-1:0] val_q, val_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [KEY_BITS-1:0] root_q, root_d;

	logic [CIW-1:0] lidx, ridx, cnt_x, nl_idx, nr_idx;
	logic [AW-1:0]  par, par_d;
	logic           l_in, r_in;
	logic           accept;

	assign accept  = cmd_valid && (state_q == ST_IDLE);
	assign lidx    = {1'b0, pos_q, 1'b1};
	assign ridx    = lidx + CIW'(1);
	assign cnt_x   = CIW'(cnt_q);
	assign l_in    = lidx < cnt_x;
	assign r_in    = ridx < cnt_x;
	assign par     = (pos_q - AW'(1)) >> 1;

	// read addresses for the next step follow the next position
	assign nl_idx  = {1'b0, pos_d, 1'b1};
	assign nr_idx  = nl_idx + CIW'(1);
	assign par_d   = (pos_d - AW'(1)) >> 1;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		pos_d    = pos_q;
		val_d    = val_q;
		cnt_d    = cnt_q;
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = val_q;
		fin      = '{done: 1'b0, status: status_q};

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					status_d = STAT_OK;
					if (command == CMD_INSERT) begin
						if (cnt_q == CW'(CAPACITY)) begin
							status_d = STAT_FULL;
							state_d  = ST_FIN;
						end else begin
							val_d   = KEY_BITS'(key);
							pos_d   = cnt_q[AW-1:0];
							cnt_d   = cnt_q + CW'(1);
							state_d = ST_UP;
						end
					end else begin
						if (cnt_q == '0) begin
							status_d = STAT_EMPTY;
							state_d  = ST_FIN;
						end else begin
							cnt_d   = cnt_q - CW'(1);
							pos_d   = '0;
							state_d = ST_LOAD;
						end
					end
				end
			end
			ST_UP: begin
				we = 1'b1;
				if (pos_q == '0) begin
					state_d = ST_FIN;
				end else if (val_q < rdata_a) begin
					state_d = ST_FIN;
				end else begin
					// equal keys move up as well
					wdata = rdata_a;
					pos_d = par;
				end
			end
			ST_LOAD: begin
				// the former last key becomes the sifting value
				val_d = rdata_a;
				if (cnt_q == '0) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_DOWN;
				end
			end
			ST_DOWN: begin
				we = 1'b1;
				if (!l_in) begin
					state_d = ST_FIN;
				end else if (!r_in) begin
					// lone left child: one more pass lands the value there
					if (val_q < rdata_a) begin
						wdata = rdata_a;
						pos_d = lidx[AW-1:0];
					end else begin
						state_d = ST_FIN;
					end
				end else if (rdata_a < val_q && rdata_b < val_q) begin
					state_d = ST_FIN;
				end else if (rdata_b < rdata_a) begin
					wdata = rdata_a;
					pos_d = lidx[AW-1:0];
				end else begin
					wdata = rdata_b;
					pos_d = ridx[AW-1:0];
				end
			end
			ST_FIN: begin
				fin.done = 1'b1;
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		root_d = root_q;
		if (we && waddr == '0) begin
			root_d = wdata;
		end
	end

	always_comb begin
		raddr_b = nr_idx[AW-1:0];
		priority if (state_d == ST_UP) begin
			raddr_a = par_d;
		end else if (state_d == ST_LOAD) begin
			raddr_a = AW'(cnt_q - CW'(1));
		end else begin
			raddr_a = nl_idx[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= STAT_OK;
			cnt_q    <= '0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			cnt_q    <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		val_q  <= val_d;
		root_q <= root_d;
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign cnt       = cnt_q;
	assign root      = root_q;

endmodule

`default_nettype wire

@@ src/binary_max_heap.sv @@
// binary_max_heap: bounded max-priority queue over a level-ordered key memory.
// Depends on bmh_pkg, bmh_store and bmh_ctrl.
//
//   channel  handshake            fields
//   cmd      cmd_valid/cmd_stall  command, key
//   res      res_valid/res_stall  top_key, top_valid, entry_count, status
//
// One item at a time. An insert climbs the heap, and a remove first loads the
// last key and then sinks it; each heap level takes one pass of the memory's
// read-compare-write loop. Refused items go straight to the result.
// Reset empties the heap at once; the key memory itself is not cleared.
// A stalled result holds in the output register; the next command is taken
// meanwhile, and its result waits until the register frees.
`default_nettype none

module binary_max_heap import bmh_pkg::*; #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_stall,
	input  wire logic             command,
	input  wire logic [KEY_W-1:0] key,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic      [KEY_W-1:0] top_key,
	output logic                  top_valid,
	output logic      [CNT_W-1:0] entry_count,
	output logic      [1:0]       status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	fin_t                fin;
	logic [CW-1:0]       cnt;
	logic [KEY_BITS-1:0] root;
	logic                we;
	logic [AW-1:0]       waddr, raddr_a, raddr_b;
	logic [KEY_BITS-1:0] wdata, rdata_a, rdata_b;
	logic                res_free;
	logic                res_valid_q;
	logic [KEY_W-1:0]    top_key_q;
	logic                top_valid_q;
	logic [CNT_W-1:0]    entry_count_q;
	status_t             status_q;

	bmh_store #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	bmh_ctrl #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (command),
		.key       (key),
		.res_free  (res_free),
		.fin       (fin),
		.cnt       (cnt),
		.root      (root),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b)
	);

	// slot is free when empty or when its result transfers this cycle
	assign res_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= fin.done;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && fin.done) begin
			top_valid_q   <= (cnt != '0);
			top_key_q     <= (cnt != '0) ? KEY_W'(root) : '0;
			entry_count_q <= CNT_W'(cnt);
			status_q      <= fin.status;
		end
	end

	assign res_valid   = res_valid_q;
	assign top_key     = top_key_q;
	assign top_valid   = top_valid_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

endmodule

`default_nettype wire
